[hw/rtl/rmx_pkg.sv]
package rmx_pkg;

  // Default sizing of the register file
  localparam int NUM_REGS_DEF   = 6;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int PTR_W   = 32;
  localparam int OPND_W  = 32;
  localparam int DEST_W  = 3;
  localparam int BIND_W  = 3;
  localparam int LEN_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IP_BINDING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_LEN   = 1'b1;

  // Opcodes
  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTIR = 4'd10,
    OP_GTRI = 4'd11,
    OP_GTRR = 4'd12,
    OP_EQIR = 4'd13,
    OP_EQRI = 4'd14,
    OP_EQRR = 4'd15
  } op_t;

  // Instruction request
  typedef struct packed {
    logic [3:0]               mode;
    logic signed [OPND_W-1:0] operand_a;
    logic signed [OPND_W-1:0] operand_b;
    logic [DEST_W-1:0]        dest_index;
  } instr_t;

  // Execution result
  typedef struct packed {
    logic signed [PTR_W-1:0] next_pointer;
    logic signed [31:0]      written_value;
    logic signed [31:0]      reg_zero;
    logic                    halted;
    logic                    fault;
  } result_t;

  // Pointer lies outside the program
  function automatic logic out_of_prog(logic [PTR_W-1:0] p, logic [LEN_W-1:0] len);
    return p[PTR_W-1] || (p >= PTR_W'(len));
  endfunction

endpackage

[hw/rtl/register_machine_execute_unit.sv]
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    in_data   (rmx_pkg::instr_t)
// out       out  out_valid/out_ready  out_data  (rmx_pkg::result_t)
// cfg       in   cfg_we               cfg_index, cfg_wdata
//
// One instruction per cycle sustained while the result side is ready; a request
// is taken into the input register and reaches the result register through
// execute and write-back; the ALU and register-file write-back are combinational.
// Synchronous reset clears the register file, pointer, halt flag and config.
// A stalled result holds the execute stage; one more request can still be
// taken into the input register while the result waits.
module register_machine_execute_unit #(
  parameter int NUM_REGS   = rmx_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rmx_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rmx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rmx_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rmx_pkg::instr_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rmx_pkg::result_t                     out_data
);

  localparam int PW = rmx_pkg::PTR_W;
  localparam logic [31:0] NREG_U = 32'(NUM_REGS);

  // Configuration
  logic [rmx_pkg::BIND_W-1:0] ip_binding;
  logic [rmx_pkg::LEN_W-1:0]  program_length;

  // Architectural state
  logic [DATA_WIDTH-1:0] rf [NUM_REGS];
  logic [PW-1:0]         ptr;
  logic                  stopped;

  // Pipeline registers
  logic             iq_valid;
  rmx_pkg::instr_t  iq_data;
  logic             oq_valid;
  rmx_pkg::result_t oq_data;
  logic             exec_fire;

  // Execute stage signals
  logic [DATA_WIDTH-1:0] rf_eff  [NUM_REGS];
  logic [DATA_WIDTH-1:0] rf_next [NUM_REGS];
  logic [DATA_WIDTH-1:0] mirror, va, vb, res, bound_val;
  logic [31:0]           opa, opb;
  logic                  bound, ra, rb, fault, start_halt, run;
  logic [PW-1:0]         ptr_next;
  logic                  stopped_next;
  rmx_pkg::op_t          op;
  rmx_pkg::result_t      res_out;

  assign exec_fire = iq_valid && (!oq_valid || out_ready);
  assign in_ready  = !iq_valid || exec_fire;
  assign out_valid = oq_valid;
  assign out_data  = oq_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ip_binding     <= '0;
      program_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rmx_pkg::CFG_IP_BINDING: ip_binding     <= cfg_wdata[rmx_pkg::BIND_W-1:0];
        rmx_pkg::CFG_PROG_LEN:   program_length <= cfg_wdata[rmx_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (in_ready) begin
      iq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      iq_data <= in_data;
    end
  end

  // Operand decode
  always_comb begin
    op = rmx_pkg::op_t'(iq_data.mode);
    ra = 1'b1;
    rb = 1'b0;
    case (op)
      rmx_pkg::OP_ADDR, rmx_pkg::OP_MULR, rmx_pkg::OP_BANR,
      rmx_pkg::OP_BORR, rmx_pkg::OP_GTRR, rmx_pkg::OP_EQRR: rb = 1'b1;
      rmx_pkg::OP_SETI: ra = 1'b0;
      rmx_pkg::OP_GTIR, rmx_pkg::OP_EQIR: begin
        ra = 1'b0;
        rb = 1'b1;
      end
      default: ;
    endcase
  end

  // Execute: pointer mirror, operand read, ALU, write-back, pointer read-back
  always_comb begin
    opa        = iq_data.operand_a;
    opb        = iq_data.operand_b;
    bound      = 32'(ip_binding) < NREG_U;
    mirror     = DATA_WIDTH'(signed'(ptr));
    start_halt = !stopped && rmx_pkg::out_of_prog(ptr, program_length);
    run        = !stopped && !start_halt;

    // register file as seen after the pointer is mirrored
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_eff[i] = (bound && 32'(ip_binding) == 32'(i)) ? mirror : rf[i];
    end

    fault = (ra && opa >= NREG_U) || (rb && opb >= NREG_U) ||
            (32'(iq_data.dest_index) >= NREG_U);

    va = DATA_WIDTH'(signed'(iq_data.operand_a));
    vb = DATA_WIDTH'(signed'(iq_data.operand_b));
    for (int i = 0; i < NUM_REGS; i++) begin
      if (ra && opa == 32'(i)) va = rf_eff[i];
      if (rb && opb == 32'(i)) vb = rf_eff[i];
    end

    case (op)
      rmx_pkg::OP_ADDR, rmx_pkg::OP_ADDI: res = va + vb;
      rmx_pkg::OP_MULR, rmx_pkg::OP_MULI: res = va * vb;
      rmx_pkg::OP_BANR, rmx_pkg::OP_BANI: res = va & vb;
      rmx_pkg::OP_BORR, rmx_pkg::OP_BORI: res = va | vb;
      rmx_pkg::OP_SETR, rmx_pkg::OP_SETI: res = va;
      rmx_pkg::OP_GTIR, rmx_pkg::OP_GTRI, rmx_pkg::OP_GTRR:
        res = DATA_WIDTH'($signed(va) > $signed(vb));
      default: res = DATA_WIDTH'(va == vb);
    endcase

    // destination write and pointer read-back
    bound_val = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      rf_next[i] = (!fault && 32'(iq_data.dest_index) == 32'(i)) ? res : rf_eff[i];
      if (32'(ip_binding) == 32'(i)) bound_val = rf_next[i];
    end
    ptr_next     = (bound ? PW'(signed'(bound_val)) : ptr) + PW'(1);
    stopped_next = rmx_pkg::out_of_prog(ptr_next, program_length);

    // result
    if (run) begin
      res_out.next_pointer  = ptr_next;
      res_out.written_value = fault ? '0 : 32'(res);
      res_out.reg_zero      = 32'(rf_next[0]);
      res_out.halted        = stopped_next;
      res_out.fault         = fault;
    end else begin
      res_out.next_pointer  = ptr;
      res_out.written_value = '0;
      res_out.reg_zero      = 32'(rf[0]);
      res_out.halted        = 1'b1;
      res_out.fault         = 1'b0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= '0;
      end
      ptr     <= '0;
      stopped <= 1'b0;
    end else if (exec_fire) begin
      if (run) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          rf[i] <= rf_next[i];
        end
        ptr     <= ptr_next;
        stopped <= stopped_next;
      end else begin
        stopped <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_valid <= 1'b0;
    end else if (exec_fire) begin
      oq_valid <= 1'b1;
    end else if (out_ready) begin
      oq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      oq_data <= res_out;
    end
  end

  // Checks
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("halt flag cleared without reset");

  a_halted_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    exec_fire && stopped |=> $stable(ptr)) else $error("pointer moved after halt");

  a_halt_report: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> oq_data.halted == stopped) else $error("halt report mismatch");

  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    oq_valid && oq_data.fault |-> oq_data.written_value == '0)
    else $error("faulted request reports a write");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> iq_valid && oq_valid && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

[tb/register_machine_execute_unit_tb.sv]
`timescale 1ns / 1ps

module register_machine_execute_unit_tb;

  localparam int NREGS       = rmx_pkg::NUM_REGS_DEF;
  localparam int CYCLE_LIMIT = 100000;
  localparam int LEN_MAX     = 65535;

  // Shadow of the machine: register file, pointer, halt flag and settings
  typedef struct packed {
    logic [NREGS-1:0][31:0]         regs;
    logic [31:0]                    ptr;
    logic                           stopped;
    logic [rmx_pkg::BIND_W-1:0]     ip_reg;
    logic [rmx_pkg::LEN_W-1:0]      plen;
  } machine_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [rmx_pkg::CFG_IDX_W-1:0]  cfg_index = rmx_pkg::CFG_IP_BINDING;
  logic [rmx_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  rmx_pkg::instr_t                in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  rmx_pkg::result_t               out_data;

  machine_t         machine = '0;
  rmx_pkg::result_t predicted_results[$];
  int       n_items     = 0;
  int       n_faults    = 0;
  int       n_results   = 0;
  int       n_errors    = 0;
  int       n_configs   = 0;
  int       burst_left  = 0;
  int       ready_mode  = 0;
  int       ready_tick  = 0;
  int       cycle_count = 0;
  int       halt_kind   = 0;
  logic [15:0] ready_mask = 16'b1101_1001_1110_0101;

  register_machine_execute_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Pointer outside 0 .. plen-1
  function automatic logic beyond_program(logic [31:0] p,
                                          logic [rmx_pkg::LEN_W-1:0] len);
    return p[31] || (p >= {16'b0, len});
  endfunction

  // One instruction on the shadow machine; returns the result it reports
  function automatic rmx_pkg::result_t execute_instr(input machine_t cur,
                                                     input rmx_pkg::instr_t ins,
                                                     output machine_t nxt);
    machine_t         m;
    rmx_pkg::result_t r;
    rmx_pkg::op_t     op;
    logic [31:0] ua, ub, va, vb, res, wr;
    logic        uses_a, uses_b, bad, bound;
    m   = cur;
    op  = rmx_pkg::op_t'(ins.mode);
    ua  = ins.operand_a;
    ub  = ins.operand_b;
    wr  = '0;
    bad = 1'b0;
    if (!m.stopped && beyond_program(m.ptr, m.plen)) m.stopped = 1'b1;
    if (!m.stopped) begin
      bound = (m.ip_reg < NREGS);
      if (bound) m.regs[m.ip_reg] = m.ptr;
      uses_a = 1'b1;
      uses_b = 1'b0;
      case (op)
        rmx_pkg::OP_ADDR, rmx_pkg::OP_MULR, rmx_pkg::OP_BANR,
        rmx_pkg::OP_BORR, rmx_pkg::OP_GTRR, rmx_pkg::OP_EQRR: uses_b = 1'b1;
        rmx_pkg::OP_SETI: uses_a = 1'b0;
        rmx_pkg::OP_GTIR, rmx_pkg::OP_EQIR: begin
          uses_a = 1'b0;
          uses_b = 1'b1;
        end
        default: ;
      endcase
      // register indexes are taken as unsigned
      if (uses_a && ua >= NREGS) bad = 1'b1;
      if (uses_b && ub >= NREGS) bad = 1'b1;
      if (ins.dest_index >= NREGS) bad = 1'b1;
      if (!bad) begin
        va = uses_a ? m.regs[ua[2:0]] : ua;
        vb = uses_b ? m.regs[ub[2:0]] : ub;
        case (op)
          rmx_pkg::OP_ADDR, rmx_pkg::OP_ADDI: res = va + vb;
          rmx_pkg::OP_MULR, rmx_pkg::OP_MULI: res = va * vb;
          rmx_pkg::OP_BANR, rmx_pkg::OP_BANI: res = va & vb;
          rmx_pkg::OP_BORR, rmx_pkg::OP_BORI: res = va | vb;
          rmx_pkg::OP_SETR, rmx_pkg::OP_SETI: res = va;
          rmx_pkg::OP_GTIR, rmx_pkg::OP_GTRI, rmx_pkg::OP_GTRR:
            res = ($signed(va) > $signed(vb)) ? 32'd1 : 32'd0;
          default: res = (va == vb) ? 32'd1 : 32'd0;
        endcase
        m.regs[ins.dest_index] = res;
        wr = res;
      end
      if (bound) m.ptr = m.regs[m.ip_reg];
      m.ptr = m.ptr + 32'd1;
      if (beyond_program(m.ptr, m.plen)) m.stopped = 1'b1;
    end
    r.next_pointer  = m.ptr;
    r.written_value = wr;
    r.reg_zero      = m.regs[0];
    r.halted        = m.stopped;
    r.fault         = bad;
    nxt = m;
    return r;
  endfunction

  function automatic rmx_pkg::instr_t make_instr(rmx_pkg::op_t op, logic [31:0] a,
                                                 logic [31:0] b, logic [2:0] d);
    rmx_pkg::instr_t ins;
    ins.mode       = op;
    ins.operand_a  = a;
    ins.operand_b  = b;
    ins.dest_index = d;
    return ins;
  endfunction

  // Mostly valid register numbers, with bad indexes, extremes and full-range values
  function automatic logic [31:0] draw_operand();
    logic [31:0] v;
    case ($urandom_range(9, 0))
      0: v = $urandom;
      1: case ($urandom_range(3, 0))
           0: v = 32'h7FFF_FFFF;
           1: v = 32'h8000_0000;
           2: v = 32'hFFFF_FFFF;
           default: v = 32'h0;
         endcase
      2: v = $urandom_range(15, 6);
      default: v = $urandom_range(5, 0);
    endcase
    return v;
  endfunction

  // Random instruction; when steering, anything that would leave the program or
  // run the pointer far ahead becomes a short jump through the bound register
  function automatic rmx_pkg::instr_t draw_instr(input bit steer);
    rmx_pkg::instr_t  ins;
    machine_t         scratch;
    rmx_pkg::result_t r;
    ins.mode       = 4'($urandom_range(15, 0));
    ins.operand_a  = draw_operand();
    ins.operand_b  = draw_operand();
    ins.dest_index = ($urandom_range(11, 0) == 0) ? 3'($urandom_range(7, 6))
                                                  : 3'($urandom_range(5, 0));
    r = execute_instr(machine, ins, scratch);
    if (steer && machine.ip_reg < NREGS &&
        (r.halted || $unsigned(r.next_pointer) >= 2048)) begin
      ins.mode       = rmx_pkg::OP_SETI;
      ins.operand_a  = $urandom_range(255, 0);
      ins.dest_index = machine.ip_reg;
    end
    return ins;
  endfunction

  // Drop valid and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  // Write both settings while the unit is idle
  task automatic configure(input logic [rmx_pkg::BIND_W-1:0] ip_sel,
                           input logic [rmx_pkg::LEN_W-1:0] len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= rmx_pkg::CFG_IP_BINDING;
    cfg_wdata <= rmx_pkg::CFG_DATA_W'(ip_sel);
    @(posedge clk);
    machine.ip_reg = ip_sel;
    cfg_index <= rmx_pkg::CFG_PROG_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    machine.plen = len;
    cfg_we <= 1'b0;
    n_configs++;
  endtask

  // Send one request in bursts with random gaps; predict on acceptance
  task automatic issue_instr(input rmx_pkg::instr_t ins);
    int               gap;
    machine_t         nxt;
    rmx_pkg::result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = execute_instr(machine, ins, nxt);
    machine = nxt;
    predicted_results.push_back(r);
    n_items++;
    if (r.fault) n_faults++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_results);
  endtask

  task automatic check_result(input rmx_pkg::result_t got);
    rmx_pkg::result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("result with no request outstanding", got.next_pointer, '0);
      return;
    end
    want = predicted_results.pop_front();
    n_results++;
    if (got.next_pointer !== want.next_pointer)
      report_mismatch("next_pointer", got.next_pointer, want.next_pointer);
    if (got.written_value !== want.written_value)
      report_mismatch("written_value", got.written_value, want.written_value);
    if (got.reg_zero !== want.reg_zero)
      report_mismatch("reg_zero", got.reg_zero, want.reg_zero);
    if (got.halted !== want.halted)
      report_mismatch("halted", 32'(got.halted), 32'(want.halted));
    if (got.fault !== want.fault)
      report_mismatch("fault", 32'(got.fault), 32'(want.fault));
  endtask

  // Result side: check on each handshake, stall in changing patterns
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      ready_tick <= ready_tick + 1;
      if (ready_tick % 80 == 0) ready_mode <= $urandom_range(3, 0);
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ready_mask[ready_tick % 16];
        2: out_ready <= ($urandom_range(3, 0) != 0);
        default: out_ready <= ($urandom_range(4, 0) == 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", predicted_results.size());
      $display("[register_machine_execute_unit] ERROR");
      $finish;
    end
  end

  // Every opcode with extreme operands; pointer mirrored in r5
  task automatic test_opcodes();
    configure(3'd5, LEN_MAX);
    issue_instr(make_instr(rmx_pkg::OP_SETI, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_SETI, 32'h8000_0000, 32'h0, 3'd2));
    issue_instr(make_instr(rmx_pkg::OP_ADDR, 32'd1, 32'd1, 3'd3));          // wraps
    issue_instr(make_instr(rmx_pkg::OP_ADDI, 32'd2, 32'hFFFF_FFFF, 3'd0));  // min - 1
    issue_instr(make_instr(rmx_pkg::OP_MULR, 32'd1, 32'd3, 3'd4));
    issue_instr(make_instr(rmx_pkg::OP_MULI, 32'd2, 32'h7FFF_FFFF, 3'd3));
    issue_instr(make_instr(rmx_pkg::OP_BANR, 32'd1, 32'd3, 3'd4));
    issue_instr(make_instr(rmx_pkg::OP_BANI, 32'd3, 32'h0F0F_0F0F, 3'd4));
    issue_instr(make_instr(rmx_pkg::OP_BORR, 32'd2, 32'd4, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_BORI, 32'd0, 32'h8000_0000, 3'd2));
    issue_instr(make_instr(rmx_pkg::OP_SETR, 32'd5, 32'd0, 3'd3));  // reads the pointer
    issue_instr(make_instr(rmx_pkg::OP_GTIR, 32'hFFFF_FFFF, 32'd2, 3'd4));  // signed
    issue_instr(make_instr(rmx_pkg::OP_GTRI, 32'd2, 32'd0, 3'd4));
    issue_instr(make_instr(rmx_pkg::OP_GTRR, 32'd1, 32'd2, 3'd0));
    issue_instr(make_instr(rmx_pkg::OP_EQIR, 32'd1, 32'd4, 3'd3));
    issue_instr(make_instr(rmx_pkg::OP_EQRI, 32'd4, 32'd1, 3'd3));
    issue_instr(make_instr(rmx_pkg::OP_EQRR, 32'd3, 32'd3, 3'd0));
    issue_instr(make_instr(rmx_pkg::OP_SETI, 32'd20, 32'd0, 3'd5));  // absolute jump
    issue_instr(make_instr(rmx_pkg::OP_ADDI, 32'd5, 32'd3, 3'd5));   // relative jump
  endtask

  // Bad register indexes: no write, pointer still advances
  task automatic test_faults();
    issue_instr(make_instr(rmx_pkg::OP_ADDR, 32'd6, 32'd0, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_ADDI, 32'hFFFF_FFFF, 32'd0, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_MULR, 32'd0, 32'h8000_0000, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_SETI, 32'd5, 32'd0, 3'd6));
    issue_instr(make_instr(rmx_pkg::OP_SETR, 32'd7, 32'd0, 3'd7));
    issue_instr(make_instr(rmx_pkg::OP_GTIR, 32'd123, 32'd6, 3'd0));
    issue_instr(make_instr(rmx_pkg::OP_EQIR, 32'd40000, 32'd0, 3'd2));  // immediate
  endtask

  // Pointer bound to r0, then to no register at all
  task automatic test_binding();
    configure(3'd0, LEN_MAX);
    issue_instr(make_instr(rmx_pkg::OP_ADDI, 32'd0, 32'd2, 3'd0));
    issue_instr(make_instr(rmx_pkg::OP_SETR, 32'd0, 32'd0, 3'd1));
    issue_instr(make_instr(rmx_pkg::OP_EQRR, 32'd0, 32'd1, 3'd2));
    configure(3'd7, LEN_MAX);
    issue_instr(make_instr(rmx_pkg::OP_SETI, 32'd77, 32'd0, 3'd5));
    issue_instr(make_instr(rmx_pkg::OP_ADDR, 32'd5, 32'd5, 3'd0));
    configure(3'd6, LEN_MAX);
    issue_instr(make_instr(rmx_pkg::OP_MULR, 32'd0, 32'd5, 3'd1));
  endtask

  // Random programs over several settings
  task automatic test_random_programs();
    logic [rmx_pkg::LEN_W-1:0] len;
    for (int ph = 0; ph < 6; ph++) begin
      len = ($urandom_range(3, 0) == 0) ? rmx_pkg::LEN_W'(LEN_MAX)
                                         : rmx_pkg::LEN_W'($urandom_range(LEN_MAX, 4096));
      configure(rmx_pkg::BIND_W'($urandom_range(7, 0)), len);
      repeat (66) issue_instr(draw_instr(1'b1));
    end
  endtask

  // One way of halting, then requests that must be ignored
  task automatic test_halt();
    halt_kind = $urandom_range(2, 0);
    case (halt_kind)
      0: configure(rmx_pkg::BIND_W'($urandom_range(5, 0)), '0);
      1: begin
        configure(3'd5, LEN_MAX);
        issue_instr(make_instr(rmx_pkg::OP_SETI,
                               32'h8000_0000 | ($urandom & 32'h7FFF_FFF0),
                               $urandom, 3'd5));
      end
      default: configure(3'd7, rmx_pkg::LEN_W'(machine.ptr + 32'd3));
    endcase
    repeat (18) issue_instr(draw_instr(1'b0));
    configure(rmx_pkg::BIND_W'($urandom_range(5, 0)), '0);
    issue_instr(draw_instr(1'b0));
  endtask

  initial begin
    string how;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_opcodes();
    test_faults();
    test_binding();
    test_random_programs();
    test_halt();
    wait_idle();
    repeat (10) @(posedge clk);
    case (halt_kind)
      0: how = "a zero program length";
      1: how = "a jump below zero";
      default: how = "running off the end";
    endcase
    $display("Sent %0d instructions (%0d faulting), checked %0d results, %0d settings",
             n_items, n_faults, n_results, n_configs);
    $display("Machine halted through %s; %0d mismatches", how, n_errors);
    if (n_errors == 0)
      $display("[register_machine_execute_unit] OK");
    else
      $display("[register_machine_execute_unit] ERROR");
    $finish;
  end

endmodule
